>>> src/bdht_pkg.sv
// bdht_pkg: shared types and constants of the button debounce / hold / toggle unit
// used by every module of the block; depends on nothing

package bdht_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;

    // stream payload widths in bits
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    // configuration reset values
    localparam logic            RST_ENABLED       = 1'b1;
    localparam logic            RST_TOGGLE_MODE   = 1'b0;
    localparam logic            RST_ACTIVE_LEVEL  = 1'b0;
    localparam logic [MS_W-1:0] RST_LOCKOUT_MS    = 16'd200;
    localparam logic [MS_W-1:0] RST_HOLD_INTERVAL = 16'd500;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLED       = 3'd0,
        REG_TOGGLE_MODE   = 3'd1,
        REG_ACTIVE_LEVEL  = 3'd2,
        REG_LOCKOUT_MS    = 3'd3,
        REG_HOLD_INTERVAL = 3'd4
    } reg_index_t;

    // item kinds carried in s_tuser
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    // live configuration handed from the register file to the core
    typedef struct packed {
        logic            enabled;
        logic            toggle_mode;
        logic            active_level;
        logic [MS_W-1:0] lockout_ms;
        logic [MS_W-1:0] hold_interval_ms;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic toggled_now;
        logic release_event;
        logic hold_event;
        logic press_event;
    } result_t;

endpackage

>>> src/bdht_cfg_regs.sv
// bdht_cfg_regs: configuration register file of the debounce unit
// depends on bdht_pkg (register indexes, reset values, cfg_t)

module bdht_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [bdht_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [bdht_pkg::CFG_DATA_W-1:0]  wr_data,
    output bdht_pkg::cfg_t                   cfg
);

    bdht_pkg::cfg_t cfg_reg;
    bdht_pkg::cfg_t cfg_next;

    // decode one write transfer; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                bdht_pkg::REG_ENABLED:       cfg_next.enabled          = wr_data[0];
                bdht_pkg::REG_TOGGLE_MODE:   cfg_next.toggle_mode      = wr_data[0];
                bdht_pkg::REG_ACTIVE_LEVEL:  cfg_next.active_level     = wr_data[0];
                bdht_pkg::REG_LOCKOUT_MS:    cfg_next.lockout_ms       = wr_data;
                bdht_pkg::REG_HOLD_INTERVAL: cfg_next.hold_interval_ms = wr_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled          <= bdht_pkg::RST_ENABLED;
            cfg_reg.toggle_mode      <= bdht_pkg::RST_TOGGLE_MODE;
            cfg_reg.active_level     <= bdht_pkg::RST_ACTIVE_LEVEL;
            cfg_reg.lockout_ms       <= bdht_pkg::RST_LOCKOUT_MS;
            cfg_reg.hold_interval_ms <= bdht_pkg::RST_HOLD_INTERVAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/bdht_core.sv
// bdht_core: phase, elapsed-time counter and toggle latch with the per-tick decision logic
// depends on bdht_pkg (cfg_t, result_t, op_t)

module bdht_core #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                op,
    input  logic                level,
    input  bdht_pkg::cfg_t      cfg,
    output bdht_pkg::result_t   result
);

    localparam int CMP_W = (TIME_WIDTH > bdht_pkg::MS_W) ? TIME_WIDTH : bdht_pkg::MS_W;

    logic                  phase_reg;
    logic                  phase_next;
    logic [TIME_WIDTH-1:0] elapsed_reg;
    logic [TIME_WIDTH-1:0] elapsed_next;
    logic                  latch_reg;
    logic                  latch_next;

    logic                  active;
    logic [TIME_WIDTH-1:0] elapsed_inc;
    logic                  lock_pass;
    logic                  hold_pass;

    // saturating advance of the counter and both threshold compares
    assign active      = (level == cfg.active_level);
    assign elapsed_inc = (elapsed_reg == {TIME_WIDTH{1'b1}}) ? elapsed_reg
                                                             : elapsed_reg + 1'b1;
    assign lock_pass   = CMP_W'(elapsed_inc) > CMP_W'(cfg.lockout_ms);
    assign hold_pass   = CMP_W'(elapsed_inc) > CMP_W'(cfg.hold_interval_ms);

    // next state and events for one item
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        latch_next   = latch_reg;
        result       = '0;
        if (op == bdht_pkg::OP_CLEAR) begin
            latch_next           = 1'b0;
            result.release_event = 1'b1;
        end else if (cfg.enabled) begin
            elapsed_next = elapsed_inc;
            if (!phase_reg) begin
                // released: start a press once lockout has passed
                if (lock_pass && active) begin
                    phase_next   = 1'b1;
                    elapsed_next = '0;
                    if (cfg.toggle_mode) begin
                        latch_next           = !latch_reg;
                        result.press_event   = !latch_reg;
                        result.release_event = latch_reg;
                    end else begin
                        result.press_event = 1'b1;
                    end
                end
            end else if (lock_pass) begin
                // pressed: hold repeat, then end of press
                if (hold_pass) begin
                    elapsed_next      = '0;
                    result.hold_event = !cfg.toggle_mode;
                end
                if (!active) begin
                    phase_next           = 1'b0;
                    elapsed_next         = '0;
                    result.release_event = !cfg.toggle_mode;
                end
            end
        end
        result.toggled_now = latch_next;
    end

    // state registers, updated on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 1'b0;
            elapsed_reg <= '1;
            latch_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            latch_reg   <= latch_next;
        end
    end

endmodule

>>> src/button_debounce_hold_toggle_unit.sv
// button_debounce_hold_toggle_unit: top level of the button debouncer with hold repeat
// depends on bdht_pkg, bdht_cfg_regs and bdht_core
//
//   channel   direction  ports                               payload
//   s_        in         s_tvalid s_tready s_tdata s_tuser   level, op
//   m_        out        m_tvalid m_tready m_tdata           press, hold, release, toggle
//   cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// one item per cycle while s_tready is high; each item's result appears in the cycle after
// its transfer, set by the single output register behind the decision logic.
// reset (aresetn low, synchronous) restores the register defaults, the released
// phase, a saturated counter and a cleared latch.
// s_tready drops only while a result waits in the output register with m_tready low.

module button_debounce_hold_toggle_unit #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bdht_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] level, [7:1] zero
    input  logic [bdht_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] op
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bdht_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] press_event, [1] hold_event,
                                                        // [2] release_event, [3] toggled_now,
                                                        // [7:4] zero
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdht_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdht_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bdht_pkg::cfg_t    cfg;
    bdht_pkg::result_t result;
    bdht_pkg::result_t m_data_reg;
    logic              m_valid_reg;
    logic              s_transfer;

    assign cfg_ready  = 1'b1;
    assign s_tready   = !m_valid_reg || m_tready;
    assign s_transfer = s_tvalid && s_tready;

    bdht_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bdht_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (s_transfer),
        .op       (s_tuser[0]),
        .level    (s_tdata[0]),
        .cfg      (cfg),
        .result   (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_transfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg.toggled_now, m_data_reg.release_event,
                       m_data_reg.hold_event, m_data_reg.press_event};

endmodule

>>> src/bdht_checker.sv
// bdht_checker: port-level assertions for the debounce unit, bound to the top level
// depends on bdht_pkg and button_debounce_hold_toggle_unit

module bdht_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [bdht_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bdht_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // the input side is never blocked while the output register is empty
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output register");

    // a clear transfer yields a lone release with the latch dropped
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] |=>
            m_tvalid && m_tdata[2] && !m_tdata[3] && !m_tdata[0] && !m_tdata[1])
        else $error("clear did not give a release with latch low");

    // press never comes together with hold or release
    a_press_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[1] && !m_tdata[2])
        else $error("press reported together with hold or release");

endmodule

bind button_debounce_hold_toggle_unit bdht_checker u_bdht_checker (.*);
